// ----- hdl/jtd_pkg.sv -----
// Shared types, constants and tables for the joint transform and derivative unit.
package jtd_pkg;

  // Default number of CORDIC rotation stages
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  // Angles in Q.30, kept in 35-bit words
  localparam logic [34:0] TWO_PI_Q30  = 35'h1921FB544;
  localparam logic [34:0] PI_Q30      = 35'h0C90FDAA2;
  localparam logic [34:0] HALF_PI_Q30 = 35'h06487ED51;

  // 2^24 / two pi rounded down a little, so the quotient estimate is q or q-1
  localparam logic [21:0] RECIP_TWO_PI = 22'd2670170;

  // CORDIC start vector x = 1/gain in Q.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

  localparam logic signed [18:0] ONE_Q14 = 19'sd16384;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_JOINT_TYPE   = 3'd0,
    REG_JOINT_LIMITS = 3'd1,
    REG_JOINT_AXIS   = 3'd2,
    REG_ORIGIN_X     = 3'd3,
    REG_ORIGIN_Y     = 3'd4,
    REG_ORIGIN_Z     = 3'd5
  } jtd_reg_t;

  // Joint kinds
  typedef enum logic [1:0] {
    JT_FIXED      = 2'd0,
    JT_REVOLUTE   = 2'd1,
    JT_PRISMATIC  = 2'd2,
    JT_CONTINUOUS = 2'd3
  } jtd_joint_t;

  // Input beat
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] jval;
  } jtd_in_t;

  // Result beat
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
  } jtd_out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [1:0]  jtype;
    logic [31:0] limits;
    logic [47:0] axis;
    logic [63:0] row_x;
    logic [63:0] row_y;
    logic [63:0] row_z;
  } jtd_cfg_t;

  // Per-item sideband carried down the pipe
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] val;
  } jtd_side_t;

  // Reduced angle handed to the CORDIC
  typedef struct packed {
    logic signed [34:0] ang;
    logic               flip;
    jtd_side_t          side;
  } jtd_ang_t;

  // CORDIC result handed to the matrix stages
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic               flip;
    jtd_side_t          side;
  } jtd_sc_t;

  // arctan(2^-i) in Q.30
  function automatic logic [34:0] cordic_atan(input int idx);
    logic [34:0] v;
    unique case (idx)
      0:  v = 35'h03243F6A8;
      1:  v = 35'h01DAC6705;
      2:  v = 35'h00FADBAFC;
      3:  v = 35'h007F56EA6;
      4:  v = 35'h003FEAB76;
      5:  v = 35'h001FFD55B;
      6:  v = 35'h000FFFAAA;
      7:  v = 35'h0007FFF55;
      8:  v = 35'h0003FFFEA;
      9:  v = 35'h0001FFFFD;
      10: v = 35'h0000FFFFF;
      11: v = 35'h00007FFFF;
      12: v = 35'h00003FFFF;
      13: v = 35'h00001FFFF;
      14: v = 35'h00000FFFF;
      15: v = 35'h000007FFF;
      16: v = 35'h000003FFF;
      17: v = 35'h000001FFF;
      18: v = 35'h000000FFF;
      19: v = 35'h0000007FF;
      20: v = 35'h0000003FF;
      21: v = 35'h0000001FF;
      22: v = 35'h0000000FF;
      23: v = 35'h00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/jtd_angle.sv -----
// Joint value clamp and angle reduction into [-pi/2, pi/2], five pipeline stages.
module jtd_angle import jtd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  jtd_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  jtd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jtd_ang_t out_data
);

  logic [5:1] vld_r;
  logic [5:1] en;

  jtd_side_t side1_r, side2_r, side3_r, side4_r, side5_r;
  jtd_side_t side1_nxt;
  logic [15:0] mag2_r, mag_nxt;
  logic        neg2_r, neg3_r, neg_nxt;
  logic [4:0]  qe2_r, qe_nxt;
  logic [37:0] qprod;
  logic [34:0] rem3_r, rem_nxt;
  logic [37:0] qd;
  logic [34:0] rem_fix;
  logic signed [34:0] r4_r, r4_nxt;
  logic signed [34:0] ang5_r, ang_nxt;
  logic        flip5_r, flip_nxt;

  // Stage handshake chain: a stage loads when empty or when its successor loads
  always_comb begin
    en[5] = !vld_r[5] || out_ready;
    for (int k = 4; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= 5; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: clamp revolute and prismatic values to limits, fixed joint forces zero
  always_comb begin
    side1_nxt.cmd = in_data.cmd;
    side1_nxt.val = in_data.jval;
    if (cfg.jtype == JT_REVOLUTE || cfg.jtype == JT_PRISMATIC) begin
      if (side1_nxt.val < $signed(cfg.limits[15:0])) side1_nxt.val = $signed(cfg.limits[15:0]);
      if (side1_nxt.val > $signed(cfg.limits[31:16])) side1_nxt.val = $signed(cfg.limits[31:16]);
    end else if (cfg.jtype == JT_FIXED) begin
      side1_nxt.val = '0;
    end
  end

  // Stage 2: magnitude and quotient estimate by reciprocal multiply
  always_comb begin
    neg_nxt = side1_r.val[15];
    mag_nxt = neg_nxt ? 16'(-side1_r.val) : 16'(side1_r.val);
    qprod   = 38'(mag_nxt) * 38'(RECIP_TWO_PI);
    qe_nxt  = qprod[36:32];
  end

  // Stage 3: partial remainder, below twice two pi
  always_comb begin
    qd      = 38'(qe2_r) * 38'(TWO_PI_Q30);
    rem_nxt = 35'({mag2_r, 22'd0} - qd);
  end

  // Stage 4: one correction step, restore the dividend sign
  always_comb begin
    rem_fix = (rem3_r >= TWO_PI_Q30) ? rem3_r - TWO_PI_Q30 : rem3_r;
    r4_nxt  = neg3_r ? -$signed(rem_fix) : $signed(rem_fix);
  end

  // Stage 5: wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    ang_nxt  = r4_r;
    flip_nxt = 1'b0;
    if (ang_nxt > $signed(PI_Q30)) begin
      ang_nxt = ang_nxt - $signed(TWO_PI_Q30);
    end else if (ang_nxt < -$signed(PI_Q30)) begin
      ang_nxt = ang_nxt + $signed(TWO_PI_Q30);
    end
    if (ang_nxt > $signed(HALF_PI_Q30)) begin
      ang_nxt  = ang_nxt - $signed(PI_Q30);
      flip_nxt = 1'b1;
    end else if (ang_nxt < -$signed(HALF_PI_Q30)) begin
      ang_nxt  = ang_nxt + $signed(PI_Q30);
      flip_nxt = 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en[1]) side1_r <= side1_nxt;
    if (en[2]) begin
      side2_r <= side1_r;
      mag2_r  <= mag_nxt;
      neg2_r  <= neg_nxt;
      qe2_r   <= qe_nxt;
    end
    if (en[3]) begin
      side3_r <= side2_r;
      rem3_r  <= rem_nxt;
      neg3_r  <= neg2_r;
    end
    if (en[4]) begin
      side4_r <= side3_r;
      r4_r    <= r4_nxt;
    end
    if (en[5]) begin
      side5_r <= side4_r;
      ang5_r  <= ang_nxt;
      flip5_r <= flip_nxt;
    end
  end

  assign out_data.ang  = ang5_r;
  assign out_data.flip = flip5_r;
  assign out_data.side = side5_r;

  // Folded angle stays inside the CORDIC convergence range
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (ang5_r <= $signed(HALF_PI_Q30)) && (ang5_r >= -$signed(HALF_PI_Q30)))
    else $error("folded angle out of range");

  // Quotient estimate is off by at most one
  a_quot_est: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> ({1'b0, rem3_r} < {TWO_PI_Q30, 1'b0}))
    else $error("quotient estimate off by more than one");

  // Input is held off only when every stage is full and the output stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> ((&vld_r) && !out_ready))
    else $error("input stalled with a free stage");

endmodule

// ----- hdl/jtd_cordic.sv -----
// Pipelined rotation-mode CORDIC, one register stage per iteration.
module jtd_cordic import jtd_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jtd_ang_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jtd_sc_t  out_data
);

  logic [STAGES-1:0] vld_r;
  logic [STAGES:0]   en;

  logic signed [33:0] x_r [STAGES];
  logic signed [33:0] y_r [STAGES];
  logic signed [34:0] z_r [STAGES];
  logic               flip_r [STAGES];
  jtd_side_t          side_r [STAGES];

  // Stage handshake chain
  always_comb begin
    en[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // One micro-rotation per stage
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [33:0] xi, yi;
    logic signed [34:0] zi;
    logic               fi;
    jtd_side_t          si;

    if (g == 0) begin : g_first
      assign xi = CORDIC_X0;
      assign yi = '0;
      assign zi = in_data.ang;
      assign fi = in_data.flip;
      assign si = in_data.side;
    end else begin : g_next
      assign xi = x_r[g-1];
      assign yi = y_r[g-1];
      assign zi = z_r[g-1];
      assign fi = flip_r[g-1];
      assign si = side_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        flip_r[g] <= fi;
        side_r[g] <= si;
        if (zi >= 0) begin
          x_r[g] <= xi - (yi >>> g);
          y_r[g] <= yi + (xi >>> g);
          z_r[g] <= zi - $signed(cordic_atan(g));
        end else begin
          x_r[g] <= xi + (yi >>> g);
          y_r[g] <= yi - (xi >>> g);
          z_r[g] <= zi + $signed(cordic_atan(g));
        end
      end
    end
  end

  assign out_data.x    = x_r[STAGES-1];
  assign out_data.y    = y_r[STAGES-1];
  assign out_data.flip = flip_r[STAGES-1];
  assign out_data.side = side_r[STAGES-1];

endmodule

// ----- hdl/jtd_matrix.sv -----
// Local rotation build and origin product with rounding and saturation, four stages.
module jtd_matrix import jtd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  jtd_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  jtd_sc_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jtd_out_t out_data
);

  logic [4:1] vld_r;
  logic [4:1] en;

  logic signed [15:0] ax [3];
  logic signed [16:0] sk [3][3];
  logic signed [15:0] o [3][3];
  logic signed [15:0] t [3];
  logic signed [31:0] aa_r [3][3];

  jtd_side_t side1_r, side2_r;
  logic signed [17:0] s1_r, c1_r, s_nxt, c_nxt;
  logic signed [33:0] xr, yr;

  logic rot_j, prism_j;
  logic signed [18:0] pv, qv, rv;
  logic signed [55:0] e;
  logic signed [41:0] loc_r [3][3];
  logic signed [41:0] loc_nxt [3][3];
  logic signed [31:0] w_r [3];
  logic signed [31:0] w_nxt [3];

  logic signed [57:0] pm_r [3][3][3];
  logic signed [47:0] pt_r [3][3];
  logic signed [15:0] tadd_r [3];

  logic signed [59:0] macc;
  logic signed [51:0] tacc;
  logic signed [15:0] mres [3][3];
  logic signed [15:0] tres [3];
  jtd_out_t out_r, out_nxt;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7FFF;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Stage handshake chain
  always_comb begin
    en[4] = !vld_r[4] || out_ready;
    for (int k = 3; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= 4; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Unpack axis and origin, build the cross-product matrix
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[k]   = $signed(cfg.axis[16*k +: 16]);
      o[0][k] = $signed(cfg.row_x[16*k +: 16]);
      o[1][k] = $signed(cfg.row_y[16*k +: 16]);
      o[2][k] = $signed(cfg.row_z[16*k +: 16]);
    end
    t[0] = $signed(cfg.row_x[63:48]);
    t[1] = $signed(cfg.row_y[63:48]);
    t[2] = $signed(cfg.row_z[63:48]);
    sk[0][0] = '0;            sk[0][1] = -17'(ax[2]);   sk[0][2] = 17'(ax[1]);
    sk[1][0] = 17'(ax[2]);    sk[1][1] = '0;            sk[1][2] = -17'(ax[0]);
    sk[2][0] = -17'(ax[1]);   sk[2][1] = 17'(ax[0]);    sk[2][2] = '0;
  end

  // Axis outer product, follows the configuration
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        aa_r[j][k] <= 32'(ax[j]) * 32'(ax[k]);
      end
    end
  end

  // Stage 1: round sin and cos to Q1.14, undo the fold
  always_comb begin
    xr    = in_data.x + 34'sd32768;
    yr    = in_data.y + 34'sd32768;
    c_nxt = in_data.flip ? -xr[33:16] : xr[33:16];
    s_nxt = in_data.flip ? -yr[33:16] : yr[33:16];
  end

  // Stage 2: local rotation (or derivative) and prismatic translation vector
  always_comb begin
    rot_j   = (cfg.jtype == JT_REVOLUTE) || (cfg.jtype == JT_CONTINUOUS);
    prism_j = (cfg.jtype == JT_PRISMATIC);
    if (side1_r.cmd) begin
      pv = -19'(s1_r);
      qv = 19'(s1_r);
      rv = 19'(c1_r);
    end else begin
      pv = 19'(c1_r);
      qv = ONE_Q14 - 19'(c1_r);
      rv = 19'(s1_r);
    end
    e = '0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (rot_j) begin
          e = 56'(qv) * 56'(aa_r[j][k]) + ((56'(rv) * 56'(sk[j][k])) <<< 14);
          if (j == k) e = e + (56'(pv) <<< 28);
          loc_nxt[j][k] = 42'((e + 56'sd8192) >>> 14);
        end else if (!side1_r.cmd && j == k) begin
          loc_nxt[j][k] = 42'sd268435456;
        end else begin
          loc_nxt[j][k] = '0;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (!prism_j) w_nxt[k] = '0;
      else if (side1_r.cmd) w_nxt[k] = 32'(ax[k]) <<< 8;
      else w_nxt[k] = 32'(side1_r.val) * 32'(ax[k]);
    end
  end

  // Stage 4: sum partial products, round to output format, saturate
  always_comb begin
    macc = '0;
    tacc = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        macc = 60'(pm_r[i][j][0]) + 60'(pm_r[i][j][1]) + 60'(pm_r[i][j][2]);
        mres[i][j] = sat16(64'((macc + 60'sd134217728) >>> 28));
      end
      tacc = 52'(pt_r[i][0]) + 52'(pt_r[i][1]) + 52'(pt_r[i][2]) + (52'(tadd_r[i]) <<< 28);
      tres[i] = sat16(64'((tacc + 52'sd134217728) >>> 28));
    end
    out_nxt.m00 = mres[0][0];
    out_nxt.m01 = mres[0][1];
    out_nxt.m02 = mres[0][2];
    out_nxt.m10 = mres[1][0];
    out_nxt.m11 = mres[1][1];
    out_nxt.m12 = mres[1][2];
    out_nxt.m20 = mres[2][0];
    out_nxt.m21 = mres[2][1];
    out_nxt.m22 = mres[2][2];
    out_nxt.tx  = tres[0];
    out_nxt.ty  = tres[1];
    out_nxt.tz  = tres[2];
  end

  // Payload registers; stage 3 holds the origin products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      side1_r <= in_data.side;
      s1_r    <= s_nxt;
      c1_r    <= c_nxt;
    end
    if (en[2]) begin
      side2_r <= side1_r;
      loc_r   <= loc_nxt;
      w_r     <= w_nxt;
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++) begin
            pm_r[i][j][k] <= 58'(o[i][k]) * 58'(loc_r[k][j]);
          end
          pt_r[i][k] <= 48'(o[i][k]) * 48'(w_r[k]);
        end
        tadd_r[i] <= side2_r.cmd ? 16'sd0 : t[i];
      end
    end
    if (en[4]) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ----- hdl/joint_transform_and_derivative_unit.sv -----
// Top level: configuration registers and the angle, CORDIC and matrix pipeline.
//
// Use: load joint type, limits, axis and the three origin rows through the
// cfg_ write port while no beat is in flight (cfg_idx selects the register,
// cfg_wdata carries it, low bits used). Then push beats of {cmd, jval}
// on the in_ channel; each beat yields exactly one out_ beat with the 3x4
// result, in order.
// Pipeline: 5 stages of clamp and angle reduction, one stage per CORDIC
// iteration (16 at the default), 4 stages for the local matrix, the origin
// product and the final rounding.
// Throughput: one beat per cycle while out_ready stays high; every stage is a
// register with its own valid bit, and the slowest path is one 16x42-bit
// multiply in the origin product.
// Reset (synchronous, rst_n low) empties the pipe and restores the registers
// to a fixed joint with identity origin and axis along z.
// When out_ready is low the result holds in the output register; upstream
// stages keep filling any empty slots, and in_ready drops only once every
// stage is occupied.
module joint_transform_and_derivative_unit import jtd_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  jtd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output jtd_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  jtd_cfg_t cfg_r, cfg_nxt;

  logic     ang_valid, ang_ready;
  jtd_ang_t ang_data;
  logic     sc_valid, sc_ready;
  jtd_sc_t  sc_data;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_JOINT_TYPE:   cfg_nxt.jtype  = cfg_wdata[1:0];
        REG_JOINT_LIMITS: cfg_nxt.limits = cfg_wdata[31:0];
        REG_JOINT_AXIS:   cfg_nxt.axis   = cfg_wdata[47:0];
        REG_ORIGIN_X:     cfg_nxt.row_x  = cfg_wdata;
        REG_ORIGIN_Y:     cfg_nxt.row_y  = cfg_wdata;
        REG_ORIGIN_Z:     cfg_nxt.row_z  = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jtype  <= JT_FIXED;
      cfg_r.limits <= '0;
      cfg_r.axis   <= 48'h4000_0000_0000;
      cfg_r.row_x  <= 64'h0000_0000_0000_4000;
      cfg_r.row_y  <= 64'h0000_0000_4000_0000;
      cfg_r.row_z  <= 64'h0000_4000_0000_0000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  jtd_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (ang_valid),
    .out_ready (ang_ready),
    .out_data  (ang_data)
  );

  jtd_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ang_valid),
    .in_ready  (ang_ready),
    .in_data   (ang_data),
    .out_valid (sc_valid),
    .out_ready (sc_ready),
    .out_data  (sc_data)
  );

  jtd_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_data   (sc_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
